FILE: rtl/aosp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aosp_pkg: shared types and constants of the age ordered slot pool
// Action and status codes, field widths, the result record and sizing limits.
// ----------------------------------------------------------------------------
package aosp_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int DIM_W           = 13;
    localparam int BYTES_W         = 26;
    localparam int BYTES_PER_PIXEL = 3;
    localparam int PROD_W          = 2 * DIM_W;
    localparam int TRIPLE_W        = PROD_W + 2;
    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

    typedef enum logic [1:0] {
        A_PUSH   = 2'd0,
        A_REMOVE = 2'd1,
        A_CLEAR  = 2'd2,
        A_QUERY  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         slot;
        logic [3:0]         count;
        logic               any_held;
        logic [2:0]         newest_slot;
        logic [2:0]         oldest_slot;
        logic [BYTES_W-1:0] newest_bytes;
        logic [BYTES_W-1:0] oldest_bytes;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/aosp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aosp_in_if: request channel of the slot pool
// Valid/ready channel carrying one action with its frame size and position.
// ----------------------------------------------------------------------------
interface aosp_in_if import aosp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [2:0]       age_position;

    modport source (
        output valid, action, frame_width, frame_height, age_position,
        input  ready
    );
    modport sink (
        input  valid, action, frame_width, frame_height, age_position,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/aosp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aosp_out_if: result channel of the slot pool
// Valid/ready channel carrying the status and pool summary of one transaction.
// ----------------------------------------------------------------------------
interface aosp_out_if import aosp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [2:0]         slot;
    logic [3:0]         count;
    logic               any_held;
    logic [2:0]         newest_slot;
    logic [2:0]         oldest_slot;
    logic [BYTES_W-1:0] newest_bytes;
    logic [BYTES_W-1:0] oldest_bytes;

    modport source (
        output valid, status, slot, count, any_held, newest_slot, oldest_slot,
               newest_bytes, oldest_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, slot, count, any_held, newest_slot, oldest_slot,
               newest_bytes, oldest_bytes,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/aosp_bytes.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aosp_bytes: frame size store and byte size unit
// Holds width and height per slot; a lookup returns width*height*3, saturated.
// ----------------------------------------------------------------------------
module aosp_bytes import aosp_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire logic [SW-1:0]      i_wr_addr,
    input  wire logic [DIM_W-1:0]   i_width,
    input  wire logic [DIM_W-1:0]   i_height,
    input  wire logic               i_rd_en,
    input  wire logic [SW-1:0]      i_rd_addr,
    output logic                    o_done,
    output logic [BYTES_W-1:0]      o_bytes
);

    logic [2*DIM_W-1:0]  dim_mem [SLOTS];
    logic [2*DIM_W-1:0]  r_dim;
    logic [PROD_W-1:0]   r_prod;
    logic [BYTES_W-1:0]  r_bytes;
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic [TRIPLE_W-1:0] triple;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            dim_mem[i_wr_addr] <= {i_width, i_height};
        end
        r_dim <= dim_mem[i_rd_addr];
    end

    assign triple = {2'b00, r_prod} + {1'b0, r_prod, 1'b0};

    always_ff @(posedge i_clk) begin
        r_prod <= r_dim[2*DIM_W-1:DIM_W] * r_dim[DIM_W-1:0];
        if (triple > TRIPLE_W'(BYTES_MAX)) begin
            r_bytes <= BYTES_MAX;
        end else begin
            r_bytes <= triple[BYTES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_done  = r_v3;
    assign o_bytes = r_bytes;

endmodule
`default_nettype wire

FILE: rtl/aosp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aosp_ctrl: sequencer, held bits and age store of the slot pool
// Scans the slots one per cycle through a shared age adjust and compare unit.
// ----------------------------------------------------------------------------
module aosp_ctrl import aosp_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_action,
    input  wire logic [DIM_W-1:0] i_width,
    input  wire logic [DIM_W-1:0] i_height,
    input  wire logic [2:0]       i_position,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output t_result               o_res,
    output logic                  o_dim_we,
    output logic [SW-1:0]         o_dim_addr,
    output logic [DIM_W-1:0]      o_dim_width,
    output logic [DIM_W-1:0]      o_dim_height,
    output logic                  o_breq,
    output logic [SW-1:0]         o_baddr,
    input  wire logic             i_bdone,
    input  wire logic [BYTES_W-1:0] i_bytes
);

    localparam int AW = SW;
    localparam int QW = (AW > 3) ? AW : 3;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FIND = 6'b000010,
        S_UPD  = 6'b000100,
        S_BNEW = 6'b001000,
        S_BOLD = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_action r_act, n_act;
    t_status r_status, n_status;
    logic [DIM_W-1:0] r_w, n_w, r_h, n_h;
    logic [2:0] r_qp, n_qp;
    logic [SW-1:0] r_idx, n_idx, r_pidx, n_pidx, r_ins, n_ins;
    logic r_iss, n_iss, r_pv, n_pv, r_found, n_found, r_mod, n_mod;
    logic [SLOTS-1:0] r_held, n_held;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_hnew, n_hnew, r_hold, n_hold;
    logic [SW-1:0] r_new_s, n_new_s, r_old_s, n_old_s;
    logic [AW-1:0] r_new_a, n_new_a, r_old_a, n_old_a;
    logic [BYTES_W-1:0] r_new_b, n_new_b, r_old_b, n_old_b;
    logic r_breq, n_breq;
    logic [SW-1:0] r_baddr, n_baddr;

    logic [AW-1:0] age_mem [SLOTS];
    logic [AW-1:0] r_age_rd;
    logic          age_we;
    logic [AW-1:0] na;
    logic [AW-1:0] adj;
    logic          nh;
    logic          cur_held;
    logic [QW-1:0] age_x;
    logic [QW-1:0] qp_x;
    logic          hit;
    logic          above;
    logic          found_now;
    logic [SW+2:0] slot_ext;
    logic [SW+2:0] new_ext;
    logic [SW+2:0] old_ext;
    logic [CW+3:0] cnt_ext;

    assign cur_held = r_held[r_pidx];
    assign age_x    = QW'(r_age_rd);
    assign qp_x     = QW'(r_qp);
    assign hit      = cur_held && (age_x == qp_x);
    assign above    = cur_held && (age_x > qp_x);
    assign adj      = r_age_rd + ((r_act == A_PUSH) ? AW'(1) : {AW{1'b1}});

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_status = r_status;
        n_w      = r_w;
        n_h      = r_h;
        n_qp     = r_qp;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_ins    = r_ins;
        n_iss    = r_iss;
        n_pv     = r_pv;
        n_found  = r_found;
        n_mod    = r_mod;
        n_held   = r_held;
        n_cnt    = r_cnt;
        n_hnew   = r_hnew;
        n_hold   = r_hold;
        n_new_s  = r_new_s;
        n_old_s  = r_old_s;
        n_new_a  = r_new_a;
        n_old_a  = r_old_a;
        n_new_b  = r_new_b;
        n_old_b  = r_old_b;
        n_breq   = 1'b0;
        n_baddr  = r_baddr;
        age_we   = 1'b0;
        na       = r_age_rd;
        nh       = cur_held;
        found_now = r_found;

        if ((r_state == S_FIND) || (r_state == S_UPD)) begin
            if (r_iss) begin
                n_pv   = 1'b1;
                n_pidx = r_idx;
                if (r_idx == LAST) begin
                    n_iss = 1'b0;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end else begin
                n_pv = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act    = t_action'(i_action);
                    n_w      = i_width;
                    n_h      = i_height;
                    n_qp     = i_position;
                    n_idx    = '0;
                    n_iss    = 1'b1;
                    n_pv     = 1'b0;
                    n_found  = 1'b0;
                    n_mod    = 1'b0;
                    n_ins    = '0;
                    n_status = ST_OK;
                    n_cnt    = '0;
                    n_hnew   = 1'b0;
                    n_hold   = 1'b0;
                    n_new_s  = '0;
                    n_old_s  = '0;
                    unique case (t_action'(i_action))
                        A_PUSH, A_REMOVE: n_state = S_FIND;
                        A_CLEAR: begin
                            n_held  = '0;
                            n_state = S_UPD;
                        end
                        A_QUERY: n_state = S_UPD;
                    endcase
                end
            end
            S_FIND: begin
                if (r_pv) begin
                    if ((r_act == A_PUSH) && !cur_held && !r_found) begin
                        found_now = 1'b1;
                        n_ins     = r_pidx;
                    end
                    if ((r_act == A_REMOVE) && hit) begin
                        found_now = 1'b1;
                    end
                    n_found = found_now;
                    if (r_pidx == LAST) begin
                        n_state = S_UPD;
                        n_idx   = '0;
                        n_iss   = 1'b1;
                        n_pv    = 1'b0;
                        n_mod   = found_now;
                        if (!found_now) begin
                            n_status = (r_act == A_PUSH) ? ST_FULL : ST_MISSING;
                        end
                    end
                end
            end
            S_UPD: begin
                if (r_pv) begin
                    if (r_mod && (r_act == A_PUSH)) begin
                        if (r_pidx == r_ins) begin
                            nh = 1'b1;
                            na = '0;
                        end else if (cur_held) begin
                            na = adj;
                        end
                    end else if (r_mod && (r_act == A_REMOVE)) begin
                        if (hit) begin
                            nh = 1'b0;
                        end else if (above) begin
                            na = adj;
                        end
                    end
                    age_we         = 1'b1;
                    n_held[r_pidx] = nh;
                    if (nh) begin
                        n_cnt = r_cnt + CW'(1);
                        if (!r_hnew || (na < r_new_a)) begin
                            n_hnew  = 1'b1;
                            n_new_s = r_pidx;
                            n_new_a = na;
                        end
                        if (!r_hold || (na > r_old_a)) begin
                            n_hold  = 1'b1;
                            n_old_s = r_pidx;
                            n_old_a = na;
                        end
                    end
                    if (r_pidx == LAST) begin
                        n_state = S_BNEW;
                        n_breq  = 1'b1;
                        n_baddr = n_new_s;
                    end
                end
            end
            S_BNEW: begin
                if (i_bdone) begin
                    n_new_b = r_hnew ? i_bytes : '0;
                    n_breq  = 1'b1;
                    n_baddr = r_old_s;
                    n_state = S_BOLD;
                end
            end
            S_BOLD: begin
                if (i_bdone) begin
                    n_old_b = r_hold ? i_bytes : '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (age_we) begin
            age_mem[r_pidx] <= na;
        end
        r_age_rd <= age_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_iss   <= 1'b0;
            r_pv    <= 1'b0;
            r_breq  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_iss   <= n_iss;
            r_pv    <= n_pv;
            r_breq  <= n_breq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_status <= n_status;
        r_w      <= n_w;
        r_h      <= n_h;
        r_qp     <= n_qp;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_ins    <= n_ins;
        r_found  <= n_found;
        r_mod    <= n_mod;
        r_cnt    <= n_cnt;
        r_hnew   <= n_hnew;
        r_hold   <= n_hold;
        r_new_s  <= n_new_s;
        r_old_s  <= n_old_s;
        r_new_a  <= n_new_a;
        r_old_a  <= n_old_a;
        r_new_b  <= n_new_b;
        r_old_b  <= n_old_b;
        r_baddr  <= n_baddr;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_dim_we     = (r_state == S_UPD) && r_pv && r_mod && (r_act == A_PUSH)
                          && (r_pidx == r_ins);
    assign o_dim_addr   = r_pidx;
    assign o_dim_width  = r_w;
    assign o_dim_height = r_h;
    assign o_breq       = r_breq;
    assign o_baddr      = r_baddr;

    assign slot_ext = {3'b000, r_ins};
    assign new_ext  = {3'b000, r_new_s};
    assign old_ext  = {3'b000, r_old_s};
    assign cnt_ext  = {4'b0000, r_cnt};

    always_comb begin
        o_res.status       = r_status;
        o_res.slot         = (r_mod && (r_act == A_PUSH)) ? slot_ext[2:0] : 3'd0;
        o_res.count        = cnt_ext[3:0];
        o_res.any_held     = (r_cnt != '0);
        o_res.newest_slot  = r_hnew ? new_ext[2:0] : 3'd0;
        o_res.oldest_slot  = r_hold ? old_ext[2:0] : 3'd0;
        o_res.newest_bytes = r_new_b;
        o_res.oldest_bytes = r_old_b;
    end
    assign o_res_valid = (r_state == S_OUT);

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_action == A_CLEAR)) |=> (r_held == '0))
        else $error("clear left a slot held");

    a_full_all_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (r_status == ST_FULL)) |-> (&r_held))
        else $error("full reported with a free slot");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (int'(r_cnt) == $countones(r_held)))
        else $error("count differs from held slots");

    a_bdone_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bdone |-> ((r_state == S_BNEW) || (r_state == S_BOLD)))
        else $error("byte size result outside a lookup");

endmodule
`default_nettype wire

FILE: rtl/age_ordered_slot_pool_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// age_ordered_slot_pool_unit: pool of frame slots kept in dense age order
// Push, remove by age position, clear and query, with newest/oldest summary.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request transaction: action, frame width and height,
//   and the age position to remove. o_out carries one result transaction per
//   request: status, slot used, count held, newest and oldest slots and their
//   byte sizes (width * height * 3, saturated to 26 bits).
//   A push or remove scans the age store twice, once to search and once to
//   update, and a clear or query scans it once to update; the store is
//   scanned one slot per cycle, and two byte size lookups through the
//   multiplier follow before the result is loaded.
//   i_in.ready is high only while the sequencer is idle; one request is in
//   work at a time, so the next request is accepted only after the result
//   of the last one has been handed to the output register.
//   Results sit in an output register; a stalled receiver holds o_out stable
//   while the next request is already accepted and worked on, and that one
//   waits in its last state until the register frees.
//   Synchronous reset frees every slot and empties the output register.
// ----------------------------------------------------------------------------
module age_ordered_slot_pool_unit import aosp_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    aosp_in_if.sink    i_in,
    aosp_out_if.source o_out
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic               res_valid;
    logic               res_ready;
    t_result            res;
    logic               dim_we;
    logic [SW-1:0]      dim_addr;
    logic [DIM_W-1:0]   dim_width;
    logic [DIM_W-1:0]   dim_height;
    logic               breq;
    logic [SW-1:0]      baddr;
    logic               bdone;
    logic [BYTES_W-1:0] bytes_val;
    logic               r_out_valid;
    t_result            r_out;

    aosp_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_action     (i_in.action),
        .i_width      (i_in.frame_width),
        .i_height     (i_in.frame_height),
        .i_position   (i_in.age_position),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_dim_we     (dim_we),
        .o_dim_addr   (dim_addr),
        .o_dim_width  (dim_width),
        .o_dim_height (dim_height),
        .o_breq       (breq),
        .o_baddr      (baddr),
        .i_bdone      (bdone),
        .i_bytes      (bytes_val)
    );

    aosp_bytes #(.SLOTS(SLOTS)) u_bytes (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (dim_we),
        .i_wr_addr (dim_addr),
        .i_width   (dim_width),
        .i_height  (dim_height),
        .i_rd_en   (breq),
        .i_rd_addr (baddr),
        .o_done    (bdone),
        .o_bytes   (bytes_val)
    );

    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.slot         = r_out.slot;
    assign o_out.count        = r_out.count;
    assign o_out.any_held     = r_out.any_held;
    assign o_out.newest_slot  = r_out.newest_slot;
    assign o_out.oldest_slot  = r_out.oldest_slot;
    assign o_out.newest_bytes = r_out.newest_bytes;
    assign o_out.oldest_bytes = r_out.oldest_bytes;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: age ordered slot pool unit
// Sends push, remove, clear and query requests with random gaps on both
// channels. A software copy of the pool predicts every result, and each result
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import aosp_pkg::*;

    localparam int POOL_SLOTS   = SLOTS_DEF;
    localparam int PHASE_ITEMS  = 500;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 2 * POOL_SLOTS + 40;

    typedef struct {
        t_action          action;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [2:0]       position;
    } pool_request_t;

    logic i_clk;
    logic i_rst_n;

    aosp_in_if  req_ch ();
    aosp_out_if res_ch ();

    age_ordered_slot_pool_unit #(
        .SLOTS(POOL_SLOTS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (res_ch)
    );

    pool_request_t request_q[$];
    t_result       pool_summary_q[$];

    int tx_idle_pct       = 35;
    int rx_idle_pct       = 80;
    int phase_sel         = 0;
    int hold_at           = 0;
    int hold_left         = 0;
    bit hold_done         = 1'b0;
    bit req_taken         = 1'b0;
    int accepted_requests = 0;
    int fail_count        = 0;
    int stall_cycles      = 0;

    // Pool copy: held flag, age position and frame size per slot
    bit               pool_held   [POOL_SLOTS];
    int unsigned      pool_age    [POOL_SLOTS];
    logic [DIM_W-1:0] pool_width  [POOL_SLOTS];
    logic [DIM_W-1:0] pool_height [POOL_SLOTS];

    function automatic void add_request(pool_request_t rq);
        request_q.insert(request_q.size(), rq);
    endfunction

    function automatic void release_slot(int s);
        pool_held[s]   = 1'b0;
        pool_age[s]    = 0;
        pool_width[s]  = '0;
        pool_height[s] = '0;
    endfunction

    function automatic logic [BYTES_W-1:0] frame_size(int s);
        longint b;
        b = longint'(pool_width[s]) * longint'(pool_height[s]) * BYTES_PER_PIXEL;
        return (b > longint'(BYTES_MAX)) ? BYTES_MAX : b[BYTES_W-1:0];
    endfunction

    function automatic t_result pool_apply_request(pool_request_t rq);
        t_result r;
        int      ins;
        bit      found;
        int      held_count;
        int      new_s;
        int      old_s;
        bit      have;
        r     = '0;
        found = 1'b0;
        ins   = 0;
        case (rq.action)
            A_PUSH: begin
                for (int i = 0; i < POOL_SLOTS; i++) begin
                    if (!found && !pool_held[i]) begin
                        ins   = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = 0; i < POOL_SLOTS; i++) begin
                        if (pool_held[i]) pool_age[i]++;
                    end
                    pool_held[ins]   = 1'b1;
                    pool_age[ins]    = 0;
                    pool_width[ins]  = rq.width;
                    pool_height[ins] = rq.height;
                    r.slot           = ins[2:0];
                end
            end
            A_REMOVE: begin
                for (int i = 0; i < POOL_SLOTS; i++) begin
                    if (pool_held[i] && pool_age[i] == rq.position) found = 1'b1;
                end
                if (!found) begin
                    r.status = ST_MISSING;
                end else begin
                    for (int i = 0; i < POOL_SLOTS; i++) begin
                        if (pool_held[i]) begin
                            if (pool_age[i] == rq.position) release_slot(i);
                            else if (pool_age[i] > rq.position) pool_age[i]--;
                        end
                    end
                end
            end
            A_CLEAR: begin
                for (int i = 0; i < POOL_SLOTS; i++) release_slot(i);
            end
            default: ;
        endcase

        held_count = 0;
        new_s      = 0;
        old_s      = 0;
        have       = 1'b0;
        for (int i = 0; i < POOL_SLOTS; i++) begin
            if (pool_held[i]) begin
                held_count++;
                if (!have || pool_age[i] < pool_age[new_s]) new_s = i;
                if (!have || pool_age[i] > pool_age[old_s]) old_s = i;
                have = 1'b1;
            end
        end
        r.count    = held_count[3:0];
        r.any_held = (held_count != 0);
        if (have) begin
            r.newest_slot  = new_s[2:0];
            r.oldest_slot  = old_s[2:0];
            r.newest_bytes = frame_size(new_s);
            r.oldest_bytes = frame_size(old_s);
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [BYTES_W-1:0] want,
                                        logic [BYTES_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIM_W'(4096);
            2:       return DIM_W'($urandom_range(4097, 8191));
            3:       return DIM_W'(8191);
            default: return DIM_W'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic pool_request_t make_request(t_action a, int w, int h, int p);
        pool_request_t rq;
        rq.action   = a;
        rq.width    = DIM_W'(w);
        rq.height   = DIM_W'(h);
        rq.position = 3'(p);
        return rq;
    endfunction

    function automatic pool_request_t random_request(bit drain_bias);
        pool_request_t rq;
        int            pick;
        pick        = $urandom_range(0, 99);
        rq.width    = rand_dim();
        rq.height   = rand_dim();
        rq.position = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(0, 3));
        if (pick < 3) rq.action = A_CLEAR;
        else if (pick < 13) rq.action = A_QUERY;
        else if (pick < (drain_bias ? 45 : 75)) rq.action = A_PUSH;
        else rq.action = A_REMOVE;
        return rq;
    endfunction

    task automatic wait_drained();
        while (request_q.size() != 0 || req_ch.valid || pool_summary_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.action       = A_PUSH;
        req_ch.frame_width  = '0;
        req_ch.frame_height = '0;
        req_ch.age_position = '0;
        res_ch.ready        = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always #10 i_clk = ~i_clk;

    // Driver: hold the request until it is taken, then advance
    always @(negedge i_clk) begin
        pool_request_t rq;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                rq = request_q.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.action       <= rq.action;
                req_ch.frame_width  <= rq.width;
                req_ch.frame_height <= rq.height;
                req_ch.age_position <= rq.position;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off in the last phase
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (phase_sel == 2 && !hold_done && accepted_requests >= hold_at) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: check result transactions, predict on request transactions
    always @(posedge i_clk) begin
        t_result       want;
        pool_request_t rq;
        req_taken <= req_ch.valid && req_ch.ready;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pool_summary_q.size() == 0) begin
                $error("result transaction with no request outstanding");
                fail_count++;
            end else begin
                want = pool_summary_q.pop_front();
                check_field("status", want.status, res_ch.status);
                check_field("slot", want.slot, res_ch.slot);
                check_field("count", want.count, res_ch.count);
                check_field("any_held", want.any_held, res_ch.any_held);
                check_field("newest_slot", want.newest_slot, res_ch.newest_slot);
                check_field("oldest_slot", want.oldest_slot, res_ch.oldest_slot);
                check_field("newest_bytes", want.newest_bytes, res_ch.newest_bytes);
                check_field("oldest_bytes", want.oldest_bytes, res_ch.oldest_bytes);
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            rq.action   = t_action'(req_ch.action);
            rq.width    = req_ch.frame_width;
            rq.height   = req_ch.frame_height;
            rq.position = req_ch.age_position;
            pool_summary_q.insert(pool_summary_q.size(), pool_apply_request(rq));
            accepted_requests++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int mode_left;
        bit drain_bias;
        for (int i = 0; i < POOL_SLOTS; i++) release_slot(i);
        mode_left  = 0;
        drain_bias = 1'b0;

        // Directed: empty pool, size extremes, full pool, removes, clear
        add_request(make_request(A_QUERY, 8191, 8191, 7));
        add_request(make_request(A_REMOVE, 0, 0, 0));
        add_request(make_request(A_PUSH, 0, 0, 0));
        add_request(make_request(A_PUSH, 4096, 4096, 7));
        add_request(make_request(A_PUSH, 8191, 8191, 0));
        add_request(make_request(A_PUSH, 1, 1, 0));
        add_request(make_request(A_PUSH, 4097, 1, 0));
        add_request(make_request(A_PUSH, 640, 480, 0));
        add_request(make_request(A_PUSH, 1920, 1080, 0));
        add_request(make_request(A_PUSH, 3, 5, 0));
        add_request(make_request(A_PUSH, 100, 100, 0));
        add_request(make_request(A_REMOVE, 8191, 8191, 7));
        add_request(make_request(A_REMOVE, 0, 0, 0));
        add_request(make_request(A_REMOVE, 0, 0, 3));
        add_request(make_request(A_REMOVE, 0, 0, 5));
        add_request(make_request(A_PUSH, 2730, 5461, 2));
        add_request(make_request(A_PUSH, 5461, 2730, 5));
        add_request(make_request(A_QUERY, 0, 0, 0));
        add_request(make_request(A_REMOVE, 0, 0, 6));
        add_request(make_request(A_CLEAR, 8191, 8191, 7));
        add_request(make_request(A_REMOVE, 0, 0, 0));
        add_request(make_request(A_PUSH, 4096, 4096, 7));
        add_request(make_request(A_QUERY, 8191, 0, 4));
        add_request(make_request(A_CLEAR, 0, 0, 0));

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 35; rx_idle_pct = 80; end
                1: begin tx_idle_pct = 80; rx_idle_pct = 35; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            hold_at   = accepted_requests + 50;
            phase_sel = ph;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (mode_left == 0) begin
                    mode_left  = $urandom_range(8, 30);
                    drain_bias = $urandom_range(0, 1);
                end
                mode_left--;
                add_request(random_request(drain_bias));
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
